FILE: hw/rtl/soc_pkg.sv
// ----------------------------------------------------------------------------
// soc_pkg
// Shared types and constants for the second-order controller with clamp.
// ----------------------------------------------------------------------------
package soc_pkg;

  // Register field widths.
  localparam int FB_W      = 18;  // feedback coefficients, Q2.16
  localparam int EC_W      = 24;  // error coefficients, Q12.12
  localparam int CFG_W     = 24;  // widest register
  localparam int CFG_IDX_W = 3;
  localparam int DRIVE_W   = 8;
  localparam int FRAC_W    = 8;   // fraction bits of the output history

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FB_ONE = 3'd0,
    REG_FB_TWO = 3'd1,
    REG_EC_NOW = 3'd2,
    REG_EC_ONE = 3'd3,
    REG_EC_TWO = 3'd4
  } cfg_reg_t;

  // Coefficient values after reset.
  localparam logic [FB_W-1:0] FB_ONE_RST = 18'd105286;
  localparam logic [FB_W-1:0] FB_TWO_RST = 18'd39750;
  localparam logic [EC_W-1:0] EC_NOW_RST = 24'd2435907;
  localparam logic [EC_W-1:0] EC_ONE_RST = 24'd4848776;
  localparam logic [EC_W-1:0] EC_TWO_RST = 24'd2412929;

  // Coefficient set handed to the datapath.
  typedef struct packed {
    logic [FB_W-1:0] fb_one;
    logic [FB_W-1:0] fb_two;
    logic [EC_W-1:0] ec_now;
    logic [EC_W-1:0] ec_one;
    logic [EC_W-1:0] ec_two;
  } coef_t;

endpackage

FILE: hw/rtl/soc_calc.sv
// ----------------------------------------------------------------------------
// soc_calc
// Difference equation, range check and output clamp for one control step.
// ----------------------------------------------------------------------------
module soc_calc
  import soc_pkg::*;
#(
  parameter int ERROR_WIDTH = 16,
  parameter int OUTPUT_MAX  = 255,
  parameter int HIST_W      = 16
) (
  input  coef_t                    coef,
  input  logic signed [ERROR_WIDTH-1:0] e0,
  input  logic signed [ERROR_WIDTH-1:0] e1,
  input  logic signed [ERROR_WIDTH-1:0] e2,
  input  logic [HIST_W-1:0]        u1,
  input  logic [HIST_W-1:0]        u2,
  output logic [HIST_W-1:0]        newest
);

  localparam int PROD_W  = EC_W + 1 + ERROR_WIDTH;
  localparam int ESUM_W  = PROD_W + 2;
  localparam int LIM_W   = (ESUM_W > 47) ? ESUM_W : 47;
  localparam int TOT_W   = LIM_W + 9;
  localparam int FPROD_W = FB_W + HIST_W;
  localparam int FSUM_W  = FPROD_W + 1;

  localparam logic signed [LIM_W-1:0] LIMIT     = LIM_W'(1) <<< 45;
  localparam logic signed [LIM_W-1:0] NEG_LIMIT = -LIMIT;
  localparam logic signed [TOT_W-1:0] TOP       = TOT_W'(OUTPUT_MAX) <<< 24;

  logic signed [PROD_W-1:0] p_now, p_one, p_two;
  logic signed [ESUM_W-1:0] esum;
  logic signed [LIM_W-1:0]  esum_w;
  logic [FPROD_W-1:0]       q_one, q_two;
  logic signed [FSUM_W-1:0] fsum;
  logic signed [TOT_W-1:0]  total;
  logic signed [TOT_W-1:0]  clamped;

  // Error part in Q.16.
  assign p_now  = $signed({1'b0, coef.ec_now}) * e0;
  assign p_one  = $signed({1'b0, coef.ec_one}) * e1;
  assign p_two  = $signed({1'b0, coef.ec_two}) * e2;
  assign esum   = ESUM_W'(p_now) - ESUM_W'(p_one) + ESUM_W'(p_two);
  assign esum_w = LIM_W'(esum);

  // Feedback part in Q.24.
  assign q_one = FPROD_W'(coef.fb_one) * FPROD_W'(u1);
  assign q_two = FPROD_W'(coef.fb_two) * FPROD_W'(u2);
  assign fsum  = $signed({1'b0, q_one}) - $signed({1'b0, q_two});

  // Error part scaled to Q.24 plus feedback.
  assign total = (TOT_W'(esum_w) <<< 8) + TOT_W'(fsum);

  // A huge error part saturates directly; otherwise clamp the exact sum.
  always_comb begin
    priority if (esum_w > LIMIT) begin
      clamped = TOP;
    end else if (esum_w < NEG_LIMIT) begin
      clamped = '0;
    end else if (total > TOP) begin
      clamped = TOP;
    end else if (total < 0) begin
      clamped = '0;
    end else begin
      clamped = total;
    end
  end

  // Truncate to Q8.8 for the history.
  assign newest = clamped[16 +: HIST_W];

endmodule

FILE: hw/rtl/second_order_controller_sat.sv
// ----------------------------------------------------------------------------
// second_order_controller_sat
// Second-order discrete controller with the output clamped to 0..OUTPUT_MAX.
//
//   Channel | Direction | Signals                     | Content
//   s_      | in        | s_tvalid s_tready s_tdata   | error_sample, Q12.4 signed
//   m_      | out       | m_tvalid m_tready m_tdata   | drive_value, integer
//   cfg_    | in        | cfg_we cfg_index cfg_data   | coefficient writes
//
// One error sample is taken per cycle while m_tready stays high; a result
// passes through the input register, then the result register, before it is
// presented. The rate is set by the output history loop: multiply,
// five-term sum and clamp are combinational between its registers.
// Reset is synchronous and restores the coefficients and clears all histories.
// When m_tready is low the result holds, one more sample waits in the input
// register, and then s_tready drops.
// ----------------------------------------------------------------------------
module second_order_controller_sat
  import soc_pkg::*;
#(
  parameter int ERROR_WIDTH = 16,
  parameter int OUTPUT_MAX  = 255
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // Bits from 0 up: error_sample, then zero fill.
  input  logic [((ERROR_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // Bits from 0 up: drive_value.
  output logic [DRIVE_W-1:0]               m_tdata,
  input  logic                             cfg_we,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_W-1:0]                 cfg_data
);

  localparam int HIST_W = $clog2(OUTPUT_MAX + 1) + FRAC_W;

  coef_t                          coef;
  logic                           s1_valid;
  logic signed [ERROR_WIDTH-1:0]  s1_err;
  logic signed [ERROR_WIDTH-1:0]  err_hist_one, err_hist_two;
  logic [HIST_W-1:0]              out_hist_one, out_hist_two;
  logic [HIST_W-1:0]              newest;
  logic [HIST_W+DRIVE_W-1:0]      newest_ext;
  logic [DRIVE_W-1:0]             drive;
  logic                           advance;

  // The input register moves on when the result register is free or emptying.
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign m_tdata  = drive;

  soc_calc #(
    .ERROR_WIDTH (ERROR_WIDTH),
    .OUTPUT_MAX  (OUTPUT_MAX),
    .HIST_W      (HIST_W)
  ) u_calc (
    .coef   (coef),
    .e0     (s1_err),
    .e1     (err_hist_one),
    .e2     (err_hist_two),
    .u1     (out_hist_one),
    .u2     (out_hist_two),
    .newest (newest)
  );

  assign newest_ext = {{DRIVE_W{1'b0}}, newest};

  // Control state, histories and coefficients.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      err_hist_one <= '0;
      err_hist_two <= '0;
      out_hist_one <= '0;
      out_hist_two <= '0;
      coef.fb_one  <= FB_ONE_RST;
      coef.fb_two  <= FB_TWO_RST;
      coef.ec_now  <= EC_NOW_RST;
      coef.ec_one  <= EC_ONE_RST;
      coef.ec_two  <= EC_TWO_RST;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (advance) begin
        err_hist_two <= err_hist_one;
        err_hist_one <= s1_err;
        out_hist_two <= out_hist_one;
        out_hist_one <= newest;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_FB_ONE: coef.fb_one <= cfg_data[FB_W-1:0];
          REG_FB_TWO: coef.fb_two <= cfg_data[FB_W-1:0];
          REG_EC_NOW: coef.ec_now <= cfg_data[EC_W-1:0];
          REG_EC_ONE: coef.ec_one <= cfg_data[EC_W-1:0];
          REG_EC_TWO: coef.ec_two <= cfg_data[EC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_err <= $signed(s_tdata[ERROR_WIDTH-1:0]);
    end
    if (advance) begin
      drive <= newest_ext[FRAC_W +: DRIVE_W];
    end
  end

  // A step always leaves a result behind.
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("step did not produce a result");

  // The stored output never exceeds the clamp.
  a_hist_clamped: assert property (@(posedge clk) disable iff (rst)
    out_hist_one <= HIST_W'(OUTPUT_MAX) << FRAC_W)
    else $error("output history beyond clamp");

  // Output history shifts in step.
  a_hist_shift: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_hist_two == $past(out_hist_one))
    else $error("output history did not shift");

  // A stall keeps the pending sample and the newest error history.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |=>
      (s1_valid && $stable(s1_err) && $stable(err_hist_one)))
    else $error("state changed during stall");

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the second-order controller with output clamp.
// Error samples go in as stream transfers and drive values are checked
// against a fixed-point predictor kept in step with the coefficient writes.
// The bench runs a directed opening and then random phases under several
// coefficient settings and several patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import soc_pkg::*;

  localparam int     ERR_W       = 16;
  localparam int     DRIVE_MAX   = 255;
  localparam int     PHASE_ITEMS = 225;
  localparam int     NUM_PHASES  = 6;
  localparam int     STALL_LIMIT = 2000;
  localparam int     OPEN_ITEMS  = 24;
  localparam longint ESUM_SAT    = longint'(1) << 45;
  // Indexes past the register list, which the block must ignore.
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(REG_EC_TWO) + 1'b1;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [ERR_W-1:0]     s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [DRIVE_W-1:0]   m_tdata;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Predictor copy of the coefficients and histories.
  logic [FB_W-1:0]      fb_one = FB_ONE_RST;
  logic [FB_W-1:0]      fb_two = FB_TWO_RST;
  logic [EC_W-1:0]      ec_now = EC_NOW_RST;
  logic [EC_W-1:0]      ec_one = EC_ONE_RST;
  logic [EC_W-1:0]      ec_two = EC_TWO_RST;
  logic [15:0]          out_h1 = '0;
  logic [15:0]          out_h2 = '0;
  logic [ERR_W-1:0]     err_h1 = '0;
  logic [ERR_W-1:0]     err_h2 = '0;

  logic [ERR_W-1:0]     err_pending[$];
  logic [DRIVE_W-1:0]   drive_expected[$];
  logic [ERR_W-1:0]     opening[OPEN_ITEMS];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  mismatches     = 0;
  int  samples_in     = 0;
  int  drives_checked = 0;
  int  quiet_cycles   = 0;
  int  settings_run   = 0;
  bit  in_taken       = 1'b0;

  second_order_controller_sat #(
    .ERROR_WIDTH (ERR_W),
    .OUTPUT_MAX  (DRIVE_MAX)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // One controller step: five-term sum, clamp, history shift, drive value.
  function automatic logic [DRIVE_W-1:0] step_controller(input logic [ERR_W-1:0] raw);
    logic signed [ERR_W-1:0] e_s;
    logic signed [ERR_W-1:0] e1_s;
    logic signed [ERR_W-1:0] e2_s;
    longint                  esum;
    longint                  fsum;
    longint                  total;
    longint                  top;
    logic [15:0]             newest;
    e_s  = raw;
    e1_s = err_h1;
    e2_s = err_h2;
    // Error terms are Q.16; feedback terms are Q.24.
    esum = longint'(ec_now) * longint'(e_s) - longint'(ec_one) * longint'(e1_s)
         + longint'(ec_two) * longint'(e2_s);
    fsum = longint'(fb_one) * longint'(out_h1) - longint'(fb_two) * longint'(out_h2);
    top  = longint'(DRIVE_MAX) << 24;
    // A huge error part saturates without forming the full sum.
    if (esum > ESUM_SAT) begin
      total = top;
    end else if (esum < -ESUM_SAT) begin
      total = 0;
    end else begin
      total = esum * 256 + fsum;
      if (total > top) begin
        total = top;
      end else if (total < 0) begin
        total = 0;
      end
    end
    newest = 16'(total >>> 16);
    err_h2 = err_h1;
    err_h1 = raw;
    out_h2 = out_h1;
    out_h1 = newest;
    return newest[15:8];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Random error sample: mostly small errors that keep the output in range.
  function automatic logic [ERR_W-1:0] random_error();
    int pick;
    int val;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      val = int'($urandom_range(0, 16)) - 8;
    end else if (pick < 70) begin
      val = int'($urandom_range(0, 512)) - 256;
    end else if (pick < 92) begin
      val = int'($urandom_range(0, 65535));
    end else begin
      case ($urandom_range(0, 3))
        0: val = 32767;
        1: val = -32768;
        2: val = -1;
        default: val = 0;
      endcase
    end
    return ERR_W'(val);
  endfunction

  // Register write; the caller lowers the write enable after the last one.
  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_FB_ONE: fb_one = val[FB_W-1:0];
      REG_FB_TWO: fb_two = val[FB_W-1:0];
      REG_EC_NOW: ec_now = val[EC_W-1:0];
      REG_EC_ONE: ec_one = val[EC_W-1:0];
      REG_EC_TWO: ec_two = val[EC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [CFG_W-1:0] f1, input logic [CFG_W-1:0] f2,
                           input logic [CFG_W-1:0] c0, input logic [CFG_W-1:0] c1,
                           input logic [CFG_W-1:0] c2);
    write_coef(REG_FB_ONE, f1);
    write_coef(REG_FB_TWO, f2);
    write_coef(REG_EC_NOW, c0);
    write_coef(REG_EC_ONE, c1);
    write_coef(REG_EC_TWO, c2);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Hold off until every queued sample has been taken and every result seen.
  task automatic wait_drained();
    @(negedge clk);
    #1;
    while (err_pending.size() != 0 || drive_expected.size() != 0 || s_tvalid) begin
      @(negedge clk);
      #1;
    end
    repeat (3) @(negedge clk);
  endtask

  // Driver: presents samples and the receiver's ready at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!s_tvalid || in_taken) begin
        if (err_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= err_pending.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on each input transfer and checks each output transfer.
  always @(posedge clk) begin
    logic out_taken;
    logic [DRIVE_W-1:0] want;
    if (rst) begin
      in_taken     = 1'b0;
      quiet_cycles = 0;
    end else begin
      in_taken  = s_tvalid && s_tready;
      out_taken = m_tvalid && m_tready;
      if (in_taken) begin
        drive_expected.push_back(step_controller(s_tdata));
        samples_in++;
      end
      if (out_taken) begin
        if (drive_expected.size() == 0) begin
          report_mismatch("drive value with nothing outstanding", m_tdata, 0);
        end else begin
          want = drive_expected.pop_front();
          drives_checked++;
          if (m_tdata !== want) begin
            report_mismatch("drive_value", m_tdata, want);
          end
        end
      end
      // Watchdog on cycles without any transfer.
      if (in_taken || out_taken) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    opening = '{
      16'd0, 16'd1, 16'd2, 16'd4, 16'd8, 16'hFFFF, 16'hFFFE, 16'h7FFF, 16'h7FFF,
      16'h8000, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd16, 16'hFFF0, 16'd3, 16'd3,
      16'd3, 16'hFFFB, 16'd12345, 16'hCFC7, 16'h5555, 16'hAAAA
    };
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed opening under the reset coefficients, with a full drain midway.
    settings_run = 1;
    for (int i = 0; i < 12; i++) err_pending.push_back(opening[i]);
    wait_drained();
    for (int i = 12; i < OPEN_ITEMS; i++) err_pending.push_back(opening[i]);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: write_all(FB_ONE_RST, FB_TWO_RST, EC_NOW_RST, EC_ONE_RST, EC_TWO_RST);
        1: begin
          // Full-scale values; the feedback registers drop the upper bits.
          write_coef(IDX_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)), CFG_W'($urandom));
          write_all('1, '1, '1, '1, '1);
        end
        2: write_all('0, '0, '0, '0, '0);
        3: write_all(CFG_W'($urandom_range(0, 262143)), CFG_W'($urandom_range(0, 262143)),
                     CFG_W'($urandom_range(0, 65536)), CFG_W'($urandom_range(0, 65536)),
                     CFG_W'($urandom_range(0, 65536)));
        4: begin
          // Pure accumulator in the feedback with a small error gain.
          write_coef(IDX_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)), CFG_W'($urandom));
          write_all(CFG_W'(65536), '0, CFG_W'($urandom_range(0, 4096)),
                    CFG_W'($urandom_range(0, 4096)), CFG_W'($urandom_range(0, 4096)));
        end
        default: write_all(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                           CFG_W'($urandom), CFG_W'($urandom));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) err_pending.push_back(random_error());
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (drive_expected.size() != 0) begin
      report_mismatch("drive values never delivered", 0, drive_expected.size());
    end
    $display("Sent %0d error samples under %0d coefficient settings, %0d drive values checked.",
             samples_in, settings_run, drives_checked);
    $display("Idling mixes: none, sender 52%%, receiver 52%%, both 18%%; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
